// ===== hw/rtl/ipmc_pkg.sv =====
package ipmc_pkg;

  // Default header window depth in bytes
  localparam int HEADER_WINDOW_DEF = 54;

  // Descriptor queue depth (one entry per packet waiting to be read out)
  localparam int DESC_DEPTH = 4;

  // Width of the raw one's complement accumulator (nine 16-bit words)
  localparam int SUM_W = 20;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ETH_FRAMING = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MARK_ENABLE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ECN_MARK    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DSCP_MARK   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HOP_VALUE   = 3'd4;

  // Register reset values
  localparam logic       RST_ETH_FRAMING = 1'b1;
  localparam logic       RST_MARK_ENABLE = 1'b0;
  localparam logic [1:0] RST_ECN_MARK    = 2'd1;
  localparam logic [5:0] RST_DSCP_MARK   = 6'd18;
  localparam logic [7:0] RST_HOP_VALUE   = 8'd2;

  // Header layout
  localparam int ET_HI_POS     = 12;
  localparam int ET_LO_POS     = 13;
  localparam int ETH_IP_OFF    = 14;
  localparam int RAW_MIN_LEN   = 20;
  localparam int V4_HDR_LEN    = 20;
  localparam int V6_HDR_LEN    = 40;
  localparam int V4_TOS        = 1;
  localparam int V4_TTL        = 8;
  localparam int V4_CK_HI      = 10;
  localparam int V4_CK_LO      = 11;
  localparam int V6_TC_HI      = 0;
  localparam int V6_TC_LO      = 1;
  localparam int V6_HOP        = 7;

  localparam logic [15:0] ETHERTYPE_V4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_V6 = 16'h86DD;
  localparam logic [3:0]  IP_VERSION_V4 = 4'h4;

  typedef enum logic [1:0] {
    KIND_UNDECIDED = 2'd0,
    KIND_V4        = 2'd1,
    KIND_V6        = 2'd2,
    KIND_PASS      = 2'd3
  } kind_t;

  typedef struct packed {
    logic       eth_framing;
    logic       mark_enable;
    logic [1:0] ecn_mark;
    logic [5:0] dscp_mark;
    logic [7:0] hop_value;
  } cfg_t;

  // Per-packet decision handed from the scan side to the emit side
  typedef struct packed {
    kind_t            kind;
    logic [SUM_W-1:0] sum;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } emit_status_t;

  // Traffic class byte: DSCP in the upper six bits, ECN in the lower two
  function automatic logic [7:0] traffic_class(input cfg_t c);
    return {c.dscp_mark, c.ecn_mark};
  endfunction

endpackage

// ===== hw/rtl/ip_header_marker_checksum_unit.sv =====
// IPv4/IPv6 header marker with IPv4 header checksum rewrite.
// Input channel (in_valid/in_stall, in_byte, in_last) takes one packet byte
// per cycle unless stalled; in_last flags the final byte. Output channel
// (out_valid/out_stall, out_byte, out_last) returns the same bytes in
// order. The first HEADER_WINDOW bytes of a packet are held back until the
// window fills or the packet ends; the packet is then classified,
// optionally marked, and the IPv4 checksum recomputed. The held bytes leave
// at one per cycle unless stalled, via the output register, the first once
// the closing byte is taken; later bytes follow as taken once the backlog
// is gone. Throughput is one byte per cycle when unstalled, set by the
// single write and read port of the byte ring (depth: smallest power of
// two >= window + 4). in_stall rises only when the ring or the four-entry
// packet descriptor queue is full. An output stall holds out_byte/out_last;
// input keeps flowing into the ring until it or the descriptor queue fills.
// Reset empties the ring and queue and loads the register defaults; no
// clearing pass is needed. Registers must be written over the APB port at
// byte address 4*index only while the block is idle; it is not enforced.
module ip_header_marker_checksum_unit #(
  parameter int HEADER_WINDOW = ipmc_pkg::HEADER_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipmc_pkg::CFG_AW-1:0] paddr,
  input  logic [ipmc_pkg::CFG_DW-1:0] pwdata,
  output logic [ipmc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  ipmc_pkg::cfg_t         cfg;
  ipmc_pkg::desc_t        desc;
  ipmc_pkg::emit_status_t emit_status;
  logic                   acc;
  logic                   wr_release;
  logic                   desc_push;
  logic                   ring_full;
  logic                   ring_avail;
  logic                   rd_pop;
  logic [7:0]             rd_byte;
  logic                   rd_last;

  assign in_stall = ring_full || emit_status.full;
  assign acc      = in_valid && !in_stall;

  ipmc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ipmc_hdr_scan #(.HEADER_WINDOW(HEADER_WINDOW)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .acc        (acc),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .wr_release (wr_release),
    .desc_push  (desc_push),
    .desc       (desc)
  );

  ipmc_ring #(.HEADER_WINDOW(HEADER_WINDOW)) u_ring (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (acc),
    .wr_release (wr_release),
    .wr_byte    (in_byte),
    .wr_last    (in_last),
    .rd_pop     (rd_pop),
    .full       (ring_full),
    .avail      (ring_avail),
    .rd_byte    (rd_byte),
    .rd_last    (rd_last)
  );

  ipmc_emit #(.HEADER_WINDOW(HEADER_WINDOW)) u_emit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .desc_push (desc_push),
    .desc_in   (desc),
    .rd_avail  (ring_avail),
    .rd_byte   (rd_byte),
    .rd_last   (rd_last),
    .rd_pop    (rd_pop),
    .status    (emit_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

`ifndef SYNTHESIS
  // a released byte always has its packet descriptor queued
  a_desc_for_release: assert property (@(posedge clk) disable iff (rst)
    ring_avail |-> !emit_status.empty)
    else $error("released ring data without a packet descriptor");

  // a descriptor is queued only on an accepted byte that releases the window
  a_push_on_release: assert property (@(posedge clk) disable iff (rst)
    desc_push |-> (acc && wr_release))
    else $error("descriptor queued outside a window close");

  // nothing is presented right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ===== hw/rtl/ipmc_cfg_regs.sv =====
module ipmc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ipmc_pkg::CFG_AW-1:0] paddr,
  input  logic [ipmc_pkg::CFG_DW-1:0] pwdata,
  output logic [ipmc_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output ipmc_pkg::cfg_t              cfg
);

  logic                              wr_req;
  logic [ipmc_pkg::REG_IDX_W-1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_req  = psel && penable && pwrite;
  assign reg_idx = paddr[ipmc_pkg::CFG_AW-1:2];

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eth_framing <= ipmc_pkg::RST_ETH_FRAMING;
      cfg.mark_enable <= ipmc_pkg::RST_MARK_ENABLE;
      cfg.ecn_mark    <= ipmc_pkg::RST_ECN_MARK;
      cfg.dscp_mark   <= ipmc_pkg::RST_DSCP_MARK;
      cfg.hop_value   <= ipmc_pkg::RST_HOP_VALUE;
    end else if (wr_req) begin
      unique case (reg_idx)
        ipmc_pkg::REG_ETH_FRAMING: cfg.eth_framing <= pwdata[0];
        ipmc_pkg::REG_MARK_ENABLE: cfg.mark_enable <= pwdata[0];
        ipmc_pkg::REG_ECN_MARK:    cfg.ecn_mark    <= pwdata[1:0];
        ipmc_pkg::REG_DSCP_MARK:   cfg.dscp_mark   <= pwdata[5:0];
        ipmc_pkg::REG_HOP_VALUE:   cfg.hop_value   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      ipmc_pkg::REG_ETH_FRAMING: prdata = ipmc_pkg::CFG_DW'(cfg.eth_framing);
      ipmc_pkg::REG_MARK_ENABLE: prdata = ipmc_pkg::CFG_DW'(cfg.mark_enable);
      ipmc_pkg::REG_ECN_MARK:    prdata = ipmc_pkg::CFG_DW'(cfg.ecn_mark);
      ipmc_pkg::REG_DSCP_MARK:   prdata = ipmc_pkg::CFG_DW'(cfg.dscp_mark);
      ipmc_pkg::REG_HOP_VALUE:   prdata = ipmc_pkg::CFG_DW'(cfg.hop_value);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ipmc_hdr_scan.sv =====
module ipmc_hdr_scan #(
  parameter int HEADER_WINDOW = ipmc_pkg::HEADER_WINDOW_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  ipmc_pkg::cfg_t cfg,
  input  logic           acc,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  output logic           wr_release,
  output logic           desc_push,
  output ipmc_pkg::desc_t desc
);

  localparam int CW = $clog2(HEADER_WINDOW + 1);
  localparam int SW = ipmc_pkg::SUM_W;

  logic [CW-1:0]   byte_count;
  logic [CW-1:0]   count_inc;
  logic [CW-1:0]   ip_off;
  logic [CW-1:0]   pos_rel;
  logic            flushed;
  logic            flush_now;
  logic [7:0]      et_hi;
  logic [7:0]      et_lo;
  logic [3:0]      version;
  logic [7:0]      word_byte;
  logic [SW-1:0]   sum;
  logic [SW-1:0]   sum_base;
  logic [SW-1:0]   addend;
  logic [SW-1:0]   sum_next;
  logic [15:0]     ethertype;
  ipmc_pkg::kind_t kind;

  assign count_inc  = byte_count + CW'(1);
  assign flush_now  = acc && !flushed && ((count_inc == CW'(HEADER_WINDOW)) || in_last);
  // bytes after the window, and the window itself once it closes, go out
  assign wr_release = flushed || flush_now;

  assign ip_off  = cfg.eth_framing ? CW'(ipmc_pkg::ETH_IP_OFF) : '0;
  // wraps high ahead of the IP header, so only the header range compares low
  assign pos_rel = byte_count - ip_off;

  // checksum word contribution, with marked fields substituted
  always_comb begin
    word_byte = in_byte;
    if (cfg.mark_enable && pos_rel == CW'(ipmc_pkg::V4_TOS)) begin
      word_byte = ipmc_pkg::traffic_class(cfg);
    end else if (cfg.mark_enable && pos_rel == CW'(ipmc_pkg::V4_TTL)) begin
      word_byte = cfg.hop_value;
    end
    addend = '0;
    if (pos_rel < CW'(ipmc_pkg::V4_HDR_LEN) && pos_rel != CW'(ipmc_pkg::V4_CK_HI) &&
        pos_rel != CW'(ipmc_pkg::V4_CK_LO)) begin
      addend = pos_rel[0] ? SW'(word_byte) : SW'({word_byte, 8'h00});
    end
  end

  assign sum_base = (byte_count == '0) ? '0 : sum;
  assign sum_next = sum_base + addend;

  // classify on the byte count the window holds after this byte
  assign ethertype = {et_hi, et_lo};
  always_comb begin
    kind = ipmc_pkg::KIND_PASS;
    if (cfg.eth_framing) begin
      if (count_inc >= CW'(ipmc_pkg::ETH_IP_OFF)) begin
        if (ethertype == ipmc_pkg::ETHERTYPE_V4 &&
            count_inc >= CW'(ipmc_pkg::ETH_IP_OFF + ipmc_pkg::V4_HDR_LEN)) begin
          kind = ipmc_pkg::KIND_V4;
        end else if (ethertype == ipmc_pkg::ETHERTYPE_V6 &&
                     count_inc >= CW'(ipmc_pkg::ETH_IP_OFF + ipmc_pkg::V6_HDR_LEN)) begin
          kind = ipmc_pkg::KIND_V6;
        end
      end
    end else if (count_inc >= CW'(ipmc_pkg::RAW_MIN_LEN)) begin
      if (version == ipmc_pkg::IP_VERSION_V4) begin
        kind = ipmc_pkg::KIND_V4;
      end else if (count_inc >= CW'(ipmc_pkg::V6_HDR_LEN)) begin
        kind = ipmc_pkg::KIND_V6;
      end
    end
  end

  assign desc_push = flush_now;
  assign desc.kind = kind;
  assign desc.sum  = sum_next;

  // packet position tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      flushed    <= 1'b0;
    end else if (acc) begin
      if (in_last) begin
        byte_count <= '0;
        flushed    <= 1'b0;
      end else if (flush_now) begin
        flushed    <= 1'b1;
      end else if (!flushed) begin
        byte_count <= count_inc;
      end
    end
  end

  // header field capture and checksum accumulation
  always_ff @(posedge clk) begin
    if (acc && !flushed) begin
      sum <= sum_next;
      if (byte_count == CW'(ipmc_pkg::ET_HI_POS)) et_hi <= in_byte;
      if (byte_count == CW'(ipmc_pkg::ET_LO_POS)) et_lo <= in_byte;
      if (byte_count == '0) version <= in_byte[7:4];
    end
  end

endmodule

// ===== hw/rtl/ipmc_ring.sv =====
module ipmc_ring #(
  parameter int HEADER_WINDOW = ipmc_pkg::HEADER_WINDOW_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic       wr_release,
  input  logic [7:0] wr_byte,
  input  logic       wr_last,
  input  logic       rd_pop,
  output logic       full,
  output logic       avail,
  output logic [7:0] rd_byte,
  output logic       rd_last
);

  // room for a full window plus the bytes in flight behind it
  localparam int DEPTH = 2 ** $clog2(HEADER_WINDOW + 4);
  localparam int AW    = $clog2(DEPTH);

  logic [8:0]  mem [DEPTH];
  logic [AW:0] wp;
  logic [AW:0] rp;
  logic [AW:0] relp;
  logic [AW:0] rp_next;
  logic [AW:0] fill;
  logic [8:0]  rdata;

  assign rp_next = rp + (AW+1)'(rd_pop);
  assign fill    = wp - rp;
  assign full    = (fill == (AW+1)'(DEPTH));
  // bytes below the release pointer have their packet decided
  assign avail   = (relp != rp);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      relp <= '0;
    end else begin
      rp <= rp_next;
      if (wr_en) begin
        wp <= wp + (AW+1)'(1);
        if (wr_release) relp <= wp + (AW+1)'(1);
      end
    end
  end

  // storage; the head entry is kept in rdata, with write-through on a hit
  always_ff @(posedge clk) begin
    if (wr_en) mem[wp[AW-1:0]] <= {wr_last, wr_byte};
    if (wr_en && wp[AW-1:0] == rp_next[AW-1:0]) begin
      rdata <= {wr_last, wr_byte};
    end else begin
      rdata <= mem[rp_next[AW-1:0]];
    end
  end

  assign rd_byte = rdata[7:0];
  assign rd_last = rdata[8];

endmodule

// ===== hw/rtl/ipmc_emit.sv =====
module ipmc_emit #(
  parameter int HEADER_WINDOW = ipmc_pkg::HEADER_WINDOW_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ipmc_pkg::cfg_t         cfg,
  input  logic                   desc_push,
  input  ipmc_pkg::desc_t        desc_in,
  input  logic                   rd_avail,
  input  logic [7:0]             rd_byte,
  input  logic                   rd_last,
  output logic                   rd_pop,
  output ipmc_pkg::emit_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last
);

  localparam int PW = $clog2(HEADER_WINDOW + 1);
  localparam int DD = ipmc_pkg::DESC_DEPTH;
  localparam int DW = $clog2(DD);

  ipmc_pkg::desc_t desc_mem [DD];
  ipmc_pkg::desc_t head;
  logic [DW:0]     dwp;
  logic [DW:0]     drp;
  logic [PW-1:0]   rpos;
  logic [PW-1:0]   ip_off;
  logic [PW-1:0]   rel;
  logic [16:0]     fold1;
  logic [15:0]     fold2;
  logic [15:0]     cksum;
  logic [7:0]      tc;
  logic [7:0]      new_byte;

  // descriptor queue, one entry per packet
  assign head         = desc_mem[drp[DW-1:0]];
  assign status.full  = ((dwp - drp) == (DW+1)'(DD));
  assign status.empty = (dwp == drp);

  assign rd_pop = rd_avail && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (desc_push) desc_mem[dwp[DW-1:0]] <= desc_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dwp  <= '0;
      drp  <= '0;
      rpos <= '0;
    end else begin
      if (desc_push) dwp <= dwp + (DW+1)'(1);
      if (rd_pop) begin
        if (rd_last) begin
          drp  <= drp + (DW+1)'(1);
          rpos <= '0;
        end else if (rpos != PW'(HEADER_WINDOW)) begin
          rpos <= rpos + PW'(1);
        end
      end
    end
  end

  // end-around carry fold and complement
  assign fold1 = 17'(head.sum[15:0]) + 17'(head.sum[ipmc_pkg::SUM_W-1:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);
  assign cksum = ~fold2;

  assign tc     = ipmc_pkg::traffic_class(cfg);
  assign ip_off = cfg.eth_framing ? PW'(ipmc_pkg::ETH_IP_OFF) : '0;
  assign rel    = rpos - ip_off;

  // header field rewrite
  always_comb begin
    new_byte = rd_byte;
    case (head.kind)
      ipmc_pkg::KIND_V4: begin
        if (cfg.mark_enable && rel == PW'(ipmc_pkg::V4_TOS)) begin
          new_byte = tc;
        end else if (cfg.mark_enable && rel == PW'(ipmc_pkg::V4_TTL)) begin
          new_byte = cfg.hop_value;
        end else if (rel == PW'(ipmc_pkg::V4_CK_HI)) begin
          new_byte = cksum[15:8];
        end else if (rel == PW'(ipmc_pkg::V4_CK_LO)) begin
          new_byte = cksum[7:0];
        end
      end
      ipmc_pkg::KIND_V6: begin
        if (cfg.mark_enable && rel == PW'(ipmc_pkg::V6_TC_HI)) begin
          new_byte = {rd_byte[7:4], tc[7:4]};
        end else if (cfg.mark_enable && rel == PW'(ipmc_pkg::V6_TC_LO)) begin
          new_byte = {tc[3:0], rd_byte[3:0]};
        end else if (cfg.mark_enable && rel == PW'(ipmc_pkg::V6_HOP)) begin
          new_byte = cfg.hop_value;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pop) begin
      out_byte <= new_byte;
      out_last <= rd_last;
    end
  end

endmodule
